>>> rtl/sum_pkg.sv
// Shared types, constants and element conversion helpers for the sorted union merge unit.
// Used by sum_ctrl, sum_datapath and sorted_union_merge_unit; depends on nothing.
package sum_pkg;

    localparam int DEPTH      = 32;
    localparam int DATA_WIDTH = 32;
    localparam int IO_WIDTH   = 32;
    localparam int CMD_WIDTH  = 2;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [CMD_WIDTH-1:0] CMD_LOAD_A = 2'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_LOAD_B = 2'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_RUN    = 2'd2;

    typedef logic signed [DATA_WIDTH-1:0] elem_t;
    typedef logic signed [IO_WIDTH-1:0]   io_word_t;
    typedef logic [CNT_W-1:0]             cnt_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_a;
        logic load_b;
        logic start;
        logic fetch;
        logic step;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic exhausted;
        logic slot_free;
    } dp_status_t;

    // The input word is sign-extended, then narrowed to the element width.
    function automatic elem_t to_elem(io_word_t v);
        logic signed [63:0] w;
        w = 64'(v);
        return w[DATA_WIDTH-1:0];
    endfunction

    // The element is sign-extended, then narrowed to the output word width.
    function automatic io_word_t to_out(elem_t e);
        logic signed [63:0] w;
        w = 64'(e);
        return w[IO_WIDTH-1:0];
    endfunction

endpackage

>>> rtl/sum_ctrl.sv
// Controller state machine of the sorted union merge unit: input handshake and run sequencing.
// Depends on sum_pkg for command codes and the command and status structs.
module sum_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [sum_pkg::CMD_WIDTH-1:0] command,
    input  sum_pkg::dp_status_t           status,
    output sum_pkg::ctrl_cmd_t            cmd
);
    import sum_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_STEP  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       in_xfer;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd.load_a = (command == CMD_LOAD_A);
                    cmd.load_b = (command == CMD_LOAD_B);
                    if (command == CMD_RUN)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                // A step may produce a result, so it waits for a free output slot.
                if (status.slot_free)
                begin
                    cmd.step   = 1'b1;
                    state_next = status.exhausted ? ST_IDLE : ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/sum_datapath.sv
// Datapath of the sorted union merge unit: list memories, counts, read pointers and output register.
// Depends on sum_pkg for widths, element helpers and the command and status structs.
module sum_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sum_pkg::ctrl_cmd_t   cmd,
    output sum_pkg::dp_status_t  status,
    input  sum_pkg::io_word_t    value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sum_pkg::io_word_t    merged_value,
    output logic                 last,
    output logic                 is_empty,
    output logic                 dropped
);
    import sum_pkg::*;

    elem_t mem_a [DEPTH];
    elem_t mem_b [DEPTH];

    cnt_t  cnt_a_reg, cnt_a_next;
    cnt_t  cnt_b_reg, cnt_b_next;
    cnt_t  ptr_a_reg, ptr_a_next;
    cnt_t  ptr_b_reg, ptr_b_next;
    logic  ovf_reg, ovf_next;
    logic  have_reg, have_next;
    elem_t pend_reg, pend_next;
    elem_t rd_a_reg;
    elem_t rd_b_reg;

    logic     out_valid_reg, out_valid_next;
    io_word_t out_value_reg, out_value_next;
    logic     out_last_reg, out_last_next;
    logic     out_empty_reg, out_empty_next;
    logic     out_drop_reg, out_drop_next;

    elem_t elem_in;
    logic  a_room;
    logic  b_room;
    logic  a_live;
    logic  b_live;
    logic  adv_a;
    logic  adv_b;
    elem_t cand;
    logic  fresh;

    assign elem_in = to_elem(value);
    assign a_room  = (cnt_a_reg < CNT_W'(DEPTH));
    assign b_room  = (cnt_b_reg < CNT_W'(DEPTH));
    assign a_live  = (ptr_a_reg < cnt_a_reg);
    assign b_live  = (ptr_b_reg < cnt_b_reg);

    // Equal heads advance both pointers and give the value once.
    assign adv_a = a_live && (!b_live || !(rd_b_reg < rd_a_reg));
    assign adv_b = b_live && (!a_live || !(rd_a_reg < rd_b_reg));
    assign cand  = adv_a ? rd_a_reg : rd_b_reg;
    assign fresh = !have_reg || (cand != pend_reg);

    assign status.exhausted = !a_live && !b_live;
    assign status.slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load_a && a_room)
        begin
            mem_a[cnt_a_reg[ADDR_W-1:0]] <= elem_in;
        end
        if (cmd.load_b && b_room)
        begin
            mem_b[cnt_b_reg[ADDR_W-1:0]] <= elem_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            rd_a_reg <= mem_a[ptr_a_reg[ADDR_W-1:0]];
            rd_b_reg <= mem_b[ptr_b_reg[ADDR_W-1:0]];
        end
    end

    always_comb
    begin
        cnt_a_next     = cnt_a_reg;
        cnt_b_next     = cnt_b_reg;
        ptr_a_next     = ptr_a_reg;
        ptr_b_next     = ptr_b_reg;
        ovf_next       = ovf_reg;
        have_next      = have_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;
        out_drop_next  = out_drop_reg;

        if (cmd.load_a)
        begin
            if (a_room)
            begin
                cnt_a_next = cnt_a_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.load_b)
        begin
            if (b_room)
            begin
                cnt_b_next = cnt_b_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.start)
        begin
            ptr_a_next = '0;
            ptr_b_next = '0;
            have_next  = 1'b0;
        end
        if (cmd.step)
        begin
            if (!a_live && !b_live)
            begin
                // Finish: flush the held element as the final result, or mark an empty run.
                out_valid_next = 1'b1;
                out_value_next = have_reg ? to_out(pend_reg) : '0;
                out_last_next  = 1'b1;
                out_empty_next = !have_reg;
                out_drop_next  = ovf_reg;
                cnt_a_next     = '0;
                cnt_b_next     = '0;
                ovf_next       = 1'b0;
                have_next      = 1'b0;
            end
            else
            begin
                ptr_a_next = ptr_a_reg + CNT_W'(adv_a);
                ptr_b_next = ptr_b_reg + CNT_W'(adv_b);
                if (fresh)
                begin
                    // The held element is known not to be final once a new one arrives.
                    if (have_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_value_next = to_out(pend_reg);
                        out_last_next  = 1'b0;
                        out_empty_next = 1'b0;
                        out_drop_next  = ovf_reg;
                    end
                    pend_next = cand;
                    have_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            ptr_a_reg     <= '0;
            ptr_b_reg     <= '0;
            ovf_reg       <= 1'b0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_a_reg     <= cnt_a_next;
            cnt_b_reg     <= cnt_b_next;
            ptr_a_reg     <= ptr_a_next;
            ptr_b_reg     <= ptr_b_next;
            ovf_reg       <= ovf_next;
            have_reg      <= have_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg      <= pend_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
        out_drop_reg  <= out_drop_next;
    end

    assign out_valid    = out_valid_reg;
    assign merged_value = out_value_reg;
    assign last         = out_last_reg;
    assign is_empty     = out_empty_reg;
    assign dropped      = out_drop_reg;

endmodule

>>> rtl/sorted_union_merge_unit.sv
// Top level of the sorted union merge unit: joins the controller and the datapath.
// Depends on sum_pkg, sum_ctrl and sum_datapath.
//
// The unit collects two lists of signed words, A and B, through the input channel (command 0
// appends value to A, command 1 appends to B) and merges them on command 2 into their sorted
// union without duplicates, one transfer per element on the output channel, with last set on
// the final transfer of the run. A load into a full list is dropped and sets a sticky flag that
// every result of the next run reports on dropped; a run over two empty lists gives a single
// transfer with is_empty and last set and merged_value zero. Each run clears both lists and the
// flag. Command 3 is accepted and does nothing. A run clears both read pointers on start, then
// walks the lists in pointer steps, each a registered read of both list memories followed by
// the compare and pointer update, for at most count_a + count_b steps plus one finishing step;
// a step waits while the output register still holds a result that is not yet taken. No input
// is taken while a run walks the lists. One element is held back until the
// next distinct element or the end of the run shows whether it is the final one, so results
// trail the walk by one step. The output register lets the next input transfer be taken while a
// finished result still waits on out_ready.
module sorted_union_merge_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [sum_pkg::CMD_WIDTH-1:0] command,
    input  sum_pkg::io_word_t             value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output sum_pkg::io_word_t             merged_value,
    output logic                          last,
    output logic                          is_empty,
    output logic                          dropped
);
    import sum_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // The controller owns the input handshake and sequences the walk.
    sum_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .command  (command),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the lists, the pointers and the output register.
    sum_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .merged_value (merged_value),
        .last         (last),
        .is_empty     (is_empty),
        .dropped      (dropped)
    );

    // An empty-run marker is always the only and therefore final result of its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_empty |-> last)
    else $error("empty result without last");

    // An empty-run marker carries a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_empty |-> merged_value == '0)
    else $error("empty result with nonzero value");

    // A run stops further input transfers while the lists are walked.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && command == CMD_RUN |=> !in_ready)
    else $error("input taken during run");

    // Loads never produce a result on their own.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && in_valid && in_ready && command != CMD_RUN |=> !out_valid)
    else $error("result appeared after a load");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_union_merge_unit: list loads, merge runs and result transfers.
// Depends on sum_pkg and the RTL of the unit; the expected union is computed inside the bench.
module tb;

    import sum_pkg::*;

    // The package names three commands; the fourth code is accepted and does nothing.
    localparam logic [CMD_WIDTH-1:0] CMD_NOP = 2'd3;

    // Random items to generate after the directed part.
    localparam int RANDOM_ITEMS = 150;

    // Once fewer items than this are left, both sides stop idling.
    localparam int CALM_TAIL = 40;

    // Cycles to watch after the last expected result for stray transfers.
    localparam int DRAIN_CYCLES = 4 * DEPTH + 80;

    // One input transfer as the driver presents it. A set hold bit makes the driver wait
    // until every expected result has arrived before it offers the item.
    typedef struct {
        logic [CMD_WIDTH-1:0] cmd;
        logic [IO_WIDTH-1:0]  val;
        bit                   hold;
    } cmd_item_t;

    // One result transfer of a merge run.
    typedef struct {
        logic [IO_WIDTH-1:0] merged_value;
        logic                last;
        logic                is_empty;
        logic                dropped;
    } union_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid     = 1'b0;
    logic                 in_ready;
    logic [CMD_WIDTH-1:0] command      = '0;
    io_word_t             value        = '0;
    logic                 out_valid;
    logic                 out_ready    = 1'b0;
    io_word_t             merged_value;
    logic                 last;
    logic                 is_empty;
    logic                 dropped;

    // Items waiting to be driven, and results the merge is expected to give, oldest first.
    cmd_item_t     cmd_queue[$];
    union_result_t union_expect[$];

    // The bench's own copy of the unit's state.
    elem_t list_a[DEPTH];
    elem_t list_b[DEPTH];
    int    count_a;
    int    count_b;
    bit    overflow_seen;

    // The driver counts the items it has offered and the monitor counts the accepted ones.
    // While the two differ, an item is on the bus and must stay there unchanged.
    int        in_sent_count = 0;
    int        in_done_count = 0;
    int        error_count   = 0;
    int        random_count  = 0;
    int        in_gap        = 0;
    int        out_gap       = 0;
    bit        idle_phase    = 1'b1;
    bit        calm;
    cmd_item_t next_item;

    sorted_union_merge_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .merged_value (merged_value),
        .last         (last),
        .is_empty     (is_empty),
        .dropped      (dropped)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Reset is held low after start and released on a falling edge, away from the sampling edge.
    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Updates the state copy for one accepted transfer and queues the results it causes.
    // Loads append to a list unless it is full, in which case the sticky drop flag is set.
    // A run walks both lists with two pointers, takes the smaller head (equal heads once,
    // both pointers advance), drains whichever list is left, and suppresses any value equal
    // to the one emitted just before it. Two empty lists give a single empty result.
    task automatic predict_union(input logic [CMD_WIDTH-1:0] cmd, input logic [IO_WIDTH-1:0] raw);
        logic signed [63:0] wide;
        elem_t              elem;
        elem_t              pick;
        elem_t              prev;
        bit                 have_prev;
        int                 ia;
        int                 ib;
        union_result_t      res;
        union_result_t      run_out[$];
        wide      = {{32{raw[31]}}, raw};
        elem      = wide[DATA_WIDTH-1:0];
        have_prev = 1'b0;
        prev      = '0;
        ia        = 0;
        ib        = 0;
        case (cmd)
            CMD_LOAD_A:
            begin
                if (count_a < DEPTH)
                begin
                    list_a[count_a] = elem;
                    count_a++;
                end
                else
                    overflow_seen = 1'b1;
            end
            CMD_LOAD_B:
            begin
                if (count_b < DEPTH)
                begin
                    list_b[count_b] = elem;
                    count_b++;
                end
                else
                    overflow_seen = 1'b1;
            end
            CMD_RUN:
            begin
                if (count_a == 0 && count_b == 0)
                begin
                    res.merged_value = '0;
                    res.last         = 1'b1;
                    res.is_empty     = 1'b1;
                    res.dropped      = overflow_seen;
                    union_expect     = {union_expect, res};
                end
                else
                begin
                    while (ia < count_a || ib < count_b)
                    begin
                        if (ia < count_a && ib < count_b)
                        begin
                            if (list_a[ia] < list_b[ib])
                            begin
                                pick = list_a[ia];
                                ia++;
                            end
                            else if (list_b[ib] < list_a[ia])
                            begin
                                pick = list_b[ib];
                                ib++;
                            end
                            else
                            begin
                                pick = list_b[ib];
                                ia++;
                                ib++;
                            end
                        end
                        else if (ia < count_a)
                        begin
                            pick = list_a[ia];
                            ia++;
                        end
                        else
                        begin
                            pick = list_b[ib];
                            ib++;
                        end
                        if (!have_prev || pick != prev)
                        begin
                            wide             = pick;
                            res.merged_value = wide[IO_WIDTH-1:0];
                            res.last         = 1'b0;
                            res.is_empty     = 1'b0;
                            res.dropped      = overflow_seen;
                            run_out          = {run_out, res};
                            have_prev = 1'b1;
                            prev      = pick;
                        end
                    end
                    for (int k = 0; k < run_out.size(); k++)
                    begin
                        res          = run_out[k];
                        res.last     = (k == run_out.size() - 1);
                        union_expect = {union_expect, res};
                    end
                end
                count_a       = 0;
                count_b       = 0;
                overflow_seen = 1'b0;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [IO_WIDTH-1:0] want,
                               input logic [IO_WIDTH-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
            error_count++;
        end
    endtask

    // Monitor: everything is sampled at the rising edge, before the unit's own updates land.
    // Result transfers are checked first, then an accepted input transfer is predicted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (union_expect.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h last %b empty %b",
                             $realtime, merged_value, last, is_empty);
                    error_count++;
                end
                else
                begin
                    check_field("merged_value", union_expect[0].merged_value, merged_value);
                    check_field("last", IO_WIDTH'(union_expect[0].last), IO_WIDTH'(last));
                    check_field("is_empty", IO_WIDTH'(union_expect[0].is_empty),
                                IO_WIDTH'(is_empty));
                    check_field("dropped", IO_WIDTH'(union_expect[0].dropped),
                                IO_WIDTH'(dropped));
                    void'(union_expect.pop_front());
                end
            end
            if (in_valid && in_ready)
            begin
                predict_union(command, value);
                in_done_count <= in_done_count + 1;
            end
        end
    end

    // Driver: both channels change on the falling edge. Idle bursts come only while idle_phase
    // is set, which flips now and then to leave stretches without gaps, and stop altogether
    // near the end of the stimulus. An item marked hold is not offered until every expected
    // result has been taken.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            out_ready <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 39) == 0)
                idle_phase = !idle_phase;
            calm = (cmd_queue.size() < CALM_TAIL);

            if (in_sent_count == in_done_count)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (idle_phase && !calm && $urandom_range(0, 3) == 0)
                begin
                    in_gap = $urandom_range(0, 10);
                    in_valid <= 1'b0;
                end
                else if (cmd_queue.size() != 0 &&
                         !(cmd_queue[0].hold && union_expect.size() != 0))
                begin
                    next_item = cmd_queue.pop_front();
                    command       <= next_item.cmd;
                    value         <= next_item.val;
                    in_valid      <= 1'b1;
                    in_sent_count <= in_sent_count + 1;
                end
                else
                    in_valid <= 1'b0;
            end

            if (out_gap > 0)
            begin
                out_gap--;
                out_ready <= 1'b0;
            end
            else if (idle_phase && !calm && $urandom_range(0, 4) == 0)
            begin
                out_gap = $urandom_range(0, 10);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic push_item(input logic [CMD_WIDTH-1:0] cmd, input logic [IO_WIDTH-1:0] val,
                             input bit hold);
        cmd_item_t item;
        item.cmd  = cmd;
        item.val  = val;
        item.hold = hold;
        cmd_queue = {cmd_queue, item};
    endtask

    // Adds one load sequence followed by a run. Most sequences load two ascending lists
    // that start close together, so equal heads and repeated values are common; the rest
    // load unsorted values, push one list past its depth, or leave lists empty. Now and
    // then an unused command is slipped in as noise.
    task automatic add_sequence(input bit with_hold);
        int          kind;
        int          na;
        int          nb;
        int          ia;
        int          ib;
        int          step_max;
        longint      base;
        longint      va;
        longint      vb;
        bit          first;
        bit          to_a;
        logic [31:0] pick_val;
        logic [31:0] a_vals[$];
        logic [31:0] b_vals[$];
        kind  = $urandom_range(0, 9);
        first = with_hold;
        if ($urandom_range(0, 5) == 0)
        begin
            na = $urandom_range(0, DEPTH);
            nb = $urandom_range(0, DEPTH);
        end
        else
        begin
            na = $urandom_range(0, 8);
            nb = $urandom_range(0, 8);
        end
        if (kind == 8)
        begin
            if ($urandom_range(0, 1) == 1)
                na = DEPTH + $urandom_range(1, 3);
            else
                nb = DEPTH + $urandom_range(1, 3);
        end
        else if (kind == 9)
        begin
            if ($urandom_range(0, 1) == 1)
                na = 0;
            else
                nb = 0;
            if ($urandom_range(0, 2) == 0)
            begin
                na = 0;
                nb = 0;
            end
        end

        case ($urandom_range(0, 3))
            0: base = -64'sd2147483648 + $urandom_range(0, 4);
            1: base = $signed($urandom);
            2: base = longint'($urandom_range(0, 20)) - 10;
            default: base = 64'sd2147483647 - $urandom_range(0, 40);
        endcase
        case ($urandom_range(0, 2))
            0: step_max = 2;
            1: step_max = 50;
            default: step_max = 1 << 27;
        endcase
        va = base;
        vb = base + $urandom_range(0, 2);
        for (int k = 0; k < na; k++)
        begin
            pick_val = (kind == 7) ? $urandom : va[31:0];
            a_vals   = {a_vals, pick_val};
            va = va + $urandom_range(0, step_max);
            if (va > 64'sd2147483647)
                va = 64'sd2147483647;
        end
        for (int k = 0; k < nb; k++)
        begin
            if (vb > 64'sd2147483647)
                vb = 64'sd2147483647;
            pick_val = (kind == 7) ? $urandom : vb[31:0];
            b_vals   = {b_vals, pick_val};
            vb = vb + $urandom_range(0, step_max);
        end

        ia = 0;
        ib = 0;
        while (ia < na || ib < nb)
        begin
            if ($urandom_range(0, 19) == 0)
                push_item(CMD_NOP, $urandom, 1'b0);
            to_a = (ib >= nb) || (ia < na && $urandom_range(0, 1) == 1);
            if (to_a)
            begin
                push_item(CMD_LOAD_A, a_vals[ia], first);
                ia++;
            end
            else
            begin
                push_item(CMD_LOAD_B, b_vals[ib], first);
                ib++;
            end
            first = 1'b0;
            random_count++;
        end
        push_item(CMD_RUN, $urandom, first);
        random_count++;
    endtask

    // Stimulus and end of run. The directed part covers a run over two empty lists, the
    // unused command, both extremes of the value range with equal heads in both lists,
    // draining a single list with a repeated value, unsorted lists and a one-element list.
    initial
    begin
        push_item(CMD_RUN, $urandom, 1'b0);
        push_item(CMD_NOP, 32'hFFFF_FFFF, 1'b0);
        push_item(CMD_LOAD_A, 32'h8000_0000, 1'b1);
        push_item(CMD_LOAD_B, 32'h8000_0000, 1'b0);
        push_item(CMD_LOAD_A, 32'h0000_0000, 1'b0);
        push_item(CMD_LOAD_B, 32'h0000_0005, 1'b0);
        push_item(CMD_LOAD_A, 32'h7FFF_FFFF, 1'b0);
        push_item(CMD_LOAD_B, 32'h7FFF_FFFF, 1'b0);
        push_item(CMD_RUN, 32'h0000_0000, 1'b0);
        push_item(CMD_LOAD_B, 32'hFFFF_FFFF, 1'b0);
        push_item(CMD_LOAD_B, 32'hFFFF_FFFF, 1'b0);
        push_item(CMD_LOAD_B, 32'h0000_0000, 1'b0);
        push_item(CMD_RUN, 32'hFFFF_FFFF, 1'b0);
        push_item(CMD_LOAD_A, 32'd3, 1'b0);
        push_item(CMD_LOAD_A, 32'd1, 1'b0);
        push_item(CMD_LOAD_B, 32'd2, 1'b0);
        push_item(CMD_LOAD_A, 32'd3, 1'b0);
        push_item(CMD_RUN, 32'h5555_AAAA, 1'b0);
        push_item(CMD_LOAD_A, 32'd7, 1'b1);
        push_item(CMD_RUN, 32'hAAAA_5555, 1'b0);

        while (random_count < RANDOM_ITEMS)
            add_sequence($urandom_range(0, 4) == 0);

        // Wait until every item has been taken, then until every result has come, then
        // watch a while longer for stray transfers.
        while (cmd_queue.size() != 0 || in_sent_count != in_done_count)
            @(posedge clk);
        while (union_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // A lost result or a hung handshake ends the run here.
    initial
    begin
        #(10_000_000);
        $display("%0t: timeout with %0d results outstanding", $realtime, union_expect.size());
        $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
rtl/sum_pkg.sv
rtl/sum_ctrl.sv
rtl/sum_datapath.sv
rtl/sorted_union_merge_unit.sv
tb/tb.sv
